// ===== sv/gdsw_pkg.sv =====
// ----------------------------------------------------------------------------
// gdsw_pkg
// Types, constants and calendar helpers for the Gregorian date step and
// weekday block.
// ----------------------------------------------------------------------------
package gdsw_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW = 5;
  localparam int unsigned OrdW = 9;
  localparam int unsigned WdayW = 3;
  localparam int unsigned Q100W = 8;

  localparam logic [YearW-1:0] YearMin = YearW'(1);
  localparam logic [YearW-1:0] YearMax = YearW'(9999);
  localparam logic [MonthW-1:0] MonJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonDec = MonthW'(12);
  localparam logic [DayW-1:0] DayFirst = DayW'(1);
  localparam logic [DayW-1:0] DecLen = DayW'(31);

  // floor(2^19 / 100) + 1: exact quotient for every 14-bit dividend
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam int unsigned Recip100Sh = 19;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } in_t;

  typedef struct packed {
    logic [YearW-1:0]  next_year;
    logic [MonthW-1:0] next_month;
    logic [DayW-1:0]   next_day;
    logic [YearW-1:0]  prev_year;
    logic [MonthW-1:0] prev_month;
    logic [DayW-1:0]   prev_day;
    logic [OrdW-1:0]   ordinal_day;
    logic [WdayW-1:0]  weekday;
    logic              date_valid;
  } out_t;

  function automatic logic [Q100W-1:0] div100(input logic [YearW-1:0] y);
    logic [YearW+12:0] p;
    p = (YearW+13)'(y) * (YearW+13)'(Recip100);
    return p[Recip100Sh+Q100W-1:Recip100Sh];
  endfunction

  function automatic logic [YearW-1:0] mul100(input logic [Q100W-1:0] q);
    return YearW'({q, 6'b0}) + YearW'({q, 5'b0}) + YearW'({q, 2'b0});
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                  len = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11: len = DayW'(30);
      default:               len = DayW'(31);
    endcase
    return len;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [OrdW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [OrdW-1:0] c;
    unique case (m)
      4'd2:    c = OrdW'(31);
      4'd3:    c = OrdW'(59);
      4'd4:    c = OrdW'(90);
      4'd5:    c = OrdW'(120);
      4'd6:    c = OrdW'(151);
      4'd7:    c = OrdW'(181);
      4'd8:    c = OrdW'(212);
      4'd9:    c = OrdW'(243);
      4'd10:   c = OrdW'(273);
      4'd11:   c = OrdW'(304);
      4'd12:   c = OrdW'(334);
      default: c = '0;
    endcase
    return c;
  endfunction

  // (13 * wm + 8) / 5, with January and February as months 13 and 14
  function automatic logic [5:0] month_term(input logic [MonthW-1:0] m);
    logic [5:0] t;
    unique case (m)
      4'd1:    t = 6'd35;
      4'd2:    t = 6'd38;
      4'd3:    t = 6'd9;
      4'd4:    t = 6'd12;
      4'd5:    t = 6'd14;
      4'd6:    t = 6'd17;
      4'd7:    t = 6'd19;
      4'd8:    t = 6'd22;
      4'd9:    t = 6'd25;
      4'd10:   t = 6'd27;
      4'd11:   t = 6'd30;
      4'd12:   t = 6'd32;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== sv/gdsw_calc.sv =====
// ----------------------------------------------------------------------------
// gdsw_calc
// Combinational date arithmetic: validity, following and preceding date,
// day of year and weekday.
// ----------------------------------------------------------------------------
module gdsw_calc (
  input  gdsw_pkg::in_t  date_i,
  output gdsw_pkg::out_t res_o
);
  import gdsw_pkg::*;

  logic [YearW-1:0]  y;
  logic [MonthW-1:0] m;
  logic [DayW-1:0]   d;
  logic [Q100W-1:0]  y_q100;
  logic              leap;
  logic [DayW-1:0]   mlen;
  logic [DayW-1:0]   prev_mlen;
  logic              valid;
  logic [YearW-1:0]  wy;
  logic [Q100W-1:0]  wy_q100;
  logic [YearW-1:0]  wsum;
  logic [4:0]        fold1;
  logic [3:0]        fold2;
  logic [WdayW-1:0]  wday;
  out_t              res;

  assign y = date_i.year;
  assign m = date_i.month;
  assign d = date_i.day;

  // leap: y%4 == 0 and (y%100 != 0 or (y/100)%4 == 0)
  assign y_q100 = div100(y);
  assign leap = (y[1:0] == 2'b00) &&
                ((y != mul100(y_q100)) || (y_q100[1:0] == 2'b00));
  assign mlen = month_len(m, leap);
  assign prev_mlen = month_len(m - MonthW'(1), leap);

  assign valid = (y >= YearMin) && (y <= YearMax) && (m >= MonJan) &&
                 (m <= MonDec) && (d >= DayFirst) && (d <= mlen);

  // weekday sum, then mod 7 by folding octal digits (8 == 1 mod 7)
  assign wy = (m <= MonFeb) ? y - YearW'(1) : y;
  assign wy_q100 = div100(wy);
  assign wsum = wy + (wy >> 2) - YearW'(wy_q100) + YearW'(wy_q100 >> 2) +
                YearW'(month_term(m)) + YearW'(d);
  assign fold1 = 5'(wsum[2:0]) + 5'(wsum[5:3]) + 5'(wsum[8:6]) +
                 5'(wsum[11:9]) + 5'(wsum[13:12]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
  assign wday = (fold2 >= 4'd7) ? WdayW'(fold2 - 4'd7) : WdayW'(fold2);

  always_comb begin
    res = '0;
    if (d < mlen) begin
      res.next_year  = y;
      res.next_month = m;
      res.next_day   = d + DayW'(1);
    end else if (m == MonDec) begin
      res.next_year  = y + YearW'(1);
      res.next_month = MonJan;
      res.next_day   = DayFirst;
    end else begin
      res.next_year  = y;
      res.next_month = m + MonthW'(1);
      res.next_day   = DayFirst;
    end

    if (d > DayFirst) begin
      res.prev_year  = y;
      res.prev_month = m;
      res.prev_day   = d - DayW'(1);
    end else if (m == MonJan) begin
      res.prev_year  = y - YearW'(1);
      res.prev_month = MonDec;
      res.prev_day   = DecLen;
    end else begin
      res.prev_year  = y;
      res.prev_month = m - MonthW'(1);
      res.prev_day   = prev_mlen;
    end

    res.ordinal_day = days_before(m) + OrdW'(d) + OrdW'(leap && (m > MonFeb));
    res.weekday     = wday;
    res.date_valid  = 1'b1;

    if (!valid) begin
      res = '0;
    end
  end

  assign res_o = res;

endmodule

// ===== sv/gregorian_date_step_and_weekday.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_step_and_weekday
// Gregorian date step: following date, preceding date, day of year and
// weekday for each input date, with a flag for dates that do not exist.
// ----------------------------------------------------------------------------
//  channel  valid          stall          payload
//  in       in_valid_i     in_stall_o     in_data_i  (gdsw_pkg::in_t)
//  out      out_valid_o    out_stall_i    out_data_o (gdsw_pkg::out_t)
//
// One date per cycle sustained while out_stall_i is low; each date passes through
// an input register, one pass of calendar logic and a result register.
// Reset clears both valid flags only; the data registers are not reset.
// A stall on the output holds the result; the input register keeps taking
// dates until both registers are full, then in_stall_o follows out_stall_i.
// ----------------------------------------------------------------------------
module gregorian_date_step_and_weekday (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gdsw_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gdsw_pkg::out_t out_data_o
);
  import gdsw_pkg::*;

  logic  s1_valid_q;
  in_t   s1_data_q;
  logic  s2_valid_q;
  out_t  s2_data_q;
  out_t  s2_data_d;
  logic  s2_adv;
  logic  s1_adv;

  assign s2_adv = !s2_valid_q || !out_stall_i;
  assign s1_adv = !s1_valid_q || s2_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (s2_adv && s1_valid_q) begin
      s2_data_q <= s2_data_d;
    end
  end

  gdsw_calc u_calc (
    .date_i (s1_data_q),
    .res_o  (s2_data_d)
  );

  assign in_stall_o  = !s1_adv;
  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

endmodule

// ===== sv/gdsw_checker.sv =====
// ----------------------------------------------------------------------------
// gdsw_checker
// Port-level checks for the date step block, bound to the top level.
// ----------------------------------------------------------------------------
module gdsw_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_o,
  input  gdsw_pkg::in_t  in_data_i,
  input  logic           out_valid_o,
  input  logic           out_stall_i,
  input  gdsw_pkg::out_t out_data_o
);
  import gdsw_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a date taken in reaches the output through both registers when nothing stalls
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after transfer");

  // a nonexistent date gives an all-zero result
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.date_valid |-> out_data_o == '0)
    else $error("invalid date with nonzero fields");

  // an existing date has a sane weekday, day of year and neighbours
  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.date_valid |->
      out_data_o.weekday <= WdayW'(6) && out_data_o.ordinal_day != '0 &&
      out_data_o.ordinal_day <= OrdW'(366) && out_data_o.next_day != '0 &&
      out_data_o.prev_day != '0)
    else $error("valid result out of range");

endmodule

bind gregorian_date_step_and_weekday gdsw_checker u_gdsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
